/* src/button_debounce_chord_detect_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button debouncer / chord detector
// Shared property forms for the checker: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CHORD_DETECT_MACROS_SVH
`define BUTTON_DEBOUNCE_CHORD_DETECT_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define BDCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define BDCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bdcd_pkg.sv */
// ----------------------------------------------------------------------------
// bdcd_pkg
// Widths, register indexes and shared types of the button debouncer.
// ----------------------------------------------------------------------------
package bdcd_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int NUM_COMBOS  = 4;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBO_A        = 3'd3;

  typedef logic [NUM_BUTTONS-1:0]                 btn_vec_t;
  typedef logic [NUM_COMBOS-1:0][NUM_BUTTONS-1:0] combo_masks_t;
  typedef logic [NUM_COMBOS-1:0]                  combo_vec_t;
  typedef logic [CNT_W-1:0]                       cnt_t;

  // What one lane reports for the current scan
  typedef struct packed {
    logic stable_next;
    logic press;
    logic release_ev;
  } lane_out_t;

endpackage

/* src/button_debounce_chord_detect.sv */
// ----------------------------------------------------------------------------
// button_debounce_chord_detect
// Takes one scan of raw pin levels per transfer, with every button debounced in
// its own lane in parallel, and returns the debounced pressed vector, press and
// release events and one fired bit per combo. A scan is accepted every cycle as
// long as the result register is free or being taken in the same cycle; the
// result appears in the cycle after the scan is accepted, held in the single output
// register behind the lanes and the combo merge. There is no clearing pass after
// reset. Configuration is written through cfg_write / cfg_index / cfg_data; an
// index with no register behind it is ignored.
// ----------------------------------------------------------------------------
module button_debounce_chord_detect
  import bdcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  btn_vec_t              raw_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output btn_vec_t              pressed_now,
  output btn_vec_t              press_events,
  output btn_vec_t              release_events,
  output combo_vec_t            combo_fired
);

  cnt_t         debounce_limit;
  btn_vec_t     active_low_mask;
  btn_vec_t     button_enable_mask;
  combo_masks_t combo_masks;

  logic       step;
  btn_vec_t   level;
  btn_vec_t   stable_vec;
  btn_vec_t   press_vec;
  btn_vec_t   release_vec;
  combo_vec_t fired;
  lane_out_t  lane_outs [NUM_BUTTONS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit     <= '0;
      active_low_mask    <= '0;
      button_enable_mask <= '0;
      combo_masks        <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DEBOUNCE_LIMIT) debounce_limit <= cfg_data[CNT_W-1:0];
      if (cfg_index == CFG_ACTIVE_LOW) active_low_mask <= cfg_data[NUM_BUTTONS-1:0];
      if (cfg_index == CFG_BUTTON_ENABLE) button_enable_mask <= cfg_data[NUM_BUTTONS-1:0];
      for (int k = 0; k < NUM_COMBOS; k++) begin
        if (cfg_index == CFG_COMBO_A + CFG_IDX_W'(k)) begin
          combo_masks[k] <= cfg_data[NUM_BUTTONS-1:0];
        end
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;
  assign level    = raw_levels ^ active_low_mask;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bdcd_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .step     (step),
      .enable   (button_enable_mask[i]),
      .want     (level[i]),
      .limit    (debounce_limit),
      .lane_out (lane_outs[i])
    );
    assign stable_vec[i]  = lane_outs[i].stable_next;
    assign press_vec[i]   = lane_outs[i].press;
    assign release_vec[i] = lane_outs[i].release_ev;
  end

  bdcd_combo u_combo (
    .stable_vec  (stable_vec),
    .press_vec   (press_vec),
    .combo_masks (combo_masks),
    .fired       (fired)
  );

  // result register: load on each accepted scan, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pressed_now    <= stable_vec;
      press_events   <= press_vec;
      release_events <= release_vec;
      combo_fired    <= fired;
    end
  end

endmodule

/* src/bdcd_lane.sv */
// ----------------------------------------------------------------------------
// bdcd_lane
// One button's debounce core: stable state bit and bounce counter.
// ----------------------------------------------------------------------------
module bdcd_lane
  import bdcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      enable,
  input  logic      want,
  input  cnt_t      limit,
  output lane_out_t lane_out
);

  logic stable;
  logic stable_next;
  cnt_t count;
  cnt_t count_next;

  always_comb begin
    stable_next         = stable;
    count_next          = count;
    lane_out.press      = 1'b0;
    lane_out.release_ev = 1'b0;
    if (!enable) begin
      // undefined button: drop state silently
      stable_next = 1'b0;
      count_next  = '0;
    end else if (want != stable) begin
      // counter is compared before its increment; it is kept when levels agree
      if (count >= limit) begin
        stable_next         = want;
        count_next          = '0;
        lane_out.press      = want;
        lane_out.release_ev = !want;
      end else begin
        count_next = count + cnt_t'(1);
      end
    end
    lane_out.stable_next = stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      count  <= '0;
    end else if (step) begin
      stable <= stable_next;
      count  <= count_next;
    end
  end

endmodule

/* src/bdcd_combo.sv */
// ----------------------------------------------------------------------------
// bdcd_combo
// Merge stage: checks each combo mask against the lanes' new state and presses.
// ----------------------------------------------------------------------------
module bdcd_combo
  import bdcd_pkg::*;
(
  input  btn_vec_t     stable_vec,
  input  btn_vec_t     press_vec,
  input  combo_masks_t combo_masks,
  output combo_vec_t   fired
);

  always_comb begin
    for (int k = 0; k < NUM_COMBOS; k++) begin
      // an empty mask never fires since no press can fall inside it
      fired[k] = ((stable_vec & combo_masks[k]) == combo_masks[k]) &&
                 ((press_vec & combo_masks[k]) != '0);
    end
  end

endmodule

/* src/bdcd_checker.sv */
// ----------------------------------------------------------------------------
// bdcd_checker
// Port-level checks of the debouncer's results, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_debounce_chord_detect_macros.svh"

module bdcd_checker
  import bdcd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input btn_vec_t   pressed_now,
  input btn_vec_t   press_events,
  input btn_vec_t   release_events,
  input combo_vec_t combo_fired
);

  `BDCD_ASSERT_NOW(a_press_is_pressed, out_valid, (press_events & ~pressed_now) == '0,
                   "press event on a button not pressed")
  `BDCD_ASSERT_NOW(a_release_is_released, out_valid, (release_events & pressed_now) == '0,
                   "release event on a button still pressed")
  `BDCD_ASSERT_NOW(a_combo_needs_press, out_valid && (press_events == '0), combo_fired == '0,
                   "combo fired without any press")
  `BDCD_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid,
                    "accepted scan produced no result")
  `BDCD_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
                    out_valid && $stable(pressed_now) && $stable(press_events) &&
                    $stable(release_events) && $stable(combo_fired),
                    "stalled result changed")

endmodule

bind button_debounce_chord_detect bdcd_checker u_bdcd_checker (.*);

/* tb/sv/bdcd_scan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdcd_scan_checker
// Watches the config port and both streams of the button debouncer, keeps its
// own copy of the debounce state, predicts each scan result on the input
// transfer and compares it field by field with the output transfer.
// ----------------------------------------------------------------------------
module bdcd_scan_checker
  import bdcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [15:0]           raw_levels,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [15:0]           pressed_now,
  input  logic [15:0]           press_events,
  input  logic [15:0]           release_events,
  input  logic [3:0]            combo_fired,
  output int                    fail_count,
  output int                    pending_results
);

  typedef struct packed {
    btn_vec_t   pressed;
    btn_vec_t   presses;
    btn_vec_t   releases;
    combo_vec_t fired;
  } scan_result_t;

  cnt_t         limit_q;
  btn_vec_t     act_low_q;
  btn_vec_t     enable_q;
  combo_masks_t combo_q;

  btn_vec_t     stable_q;
  cnt_t         bounce_q [NUM_BUTTONS];

  scan_result_t scan_results_q [$];

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEBOUNCE_LIMIT: limit_q   = data[CNT_W-1:0];
      CFG_ACTIVE_LOW:     act_low_q = data;
      CFG_BUTTON_ENABLE:  enable_q  = data;
      default: begin
        // combo registers follow combo A; anything past them is dropped
        if (idx >= CFG_COMBO_A && int'(idx - CFG_COMBO_A) < NUM_COMBOS)
          combo_q[2'(idx - CFG_COMBO_A)] = data;
      end
    endcase
  endfunction

  function automatic scan_result_t debounce_scan(btn_vec_t levels);
    scan_result_t r;
    btn_vec_t     want;
    r    = '0;
    want = levels ^ act_low_q;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (!enable_q[b]) begin
        // undefined button: drop its state silently
        stable_q[b] = 1'b0;
        bounce_q[b] = '0;
      end else if (want[b] != stable_q[b]) begin
        if (bounce_q[b] >= limit_q) begin
          bounce_q[b] = '0;
          stable_q[b] = want[b];
          if (want[b]) r.presses[b] = 1'b1;
          else r.releases[b] = 1'b1;
        end else begin
          bounce_q[b] = bounce_q[b] + cnt_t'(1);
        end
      end
    end
    for (int k = 0; k < NUM_COMBOS; k++) begin
      if ((stable_q & combo_q[k]) == combo_q[k] && (r.presses & combo_q[k]) != '0)
        r.fired[k] = 1'b1;
    end
    r.pressed = stable_q;
    return r;
  endfunction

  function automatic int field_errors(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    scan_result_t want_r;
    if (rst) begin
      limit_q   = '0;
      act_low_q = '0;
      enable_q  = '0;
      combo_q   = '0;
      stable_q  = '0;
      foreach (bounce_q[b]) bounce_q[b] = '0;
      scan_results_q.delete();
    end else begin
      if (cfg_write) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready)
        scan_results_q.insert(scan_results_q.size(), debounce_scan(raw_levels));
      if (out_valid && out_ready) begin
        if (scan_results_q.size() == 0) begin
          $error("result transfer with no scan outstanding");
          fail_count++;
        end else begin
          want_r = scan_results_q.pop_front();
          fail_count += field_errors("pressed_now", want_r.pressed, pressed_now);
          fail_count += field_errors("press_events", want_r.presses, press_events);
          fail_count += field_errors("release_events", want_r.releases, release_events);
          fail_count += field_errors("combo_fired", 16'(want_r.fired), 16'(combo_fired));
        end
      end
    end
    pending_results = scan_results_q.size();
  end

endmodule

/* tb/sv/tb_button_debounce_chord_detect.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_chord_detect
// Drives pin scans and config writes into the debouncer under several pacing
// modes: directed scans first, then held levels with bounce noise under random
// settings, then a long hold that runs a bounce counter to its top.
// ----------------------------------------------------------------------------
module tb_button_debounce_chord_detect;
  import bdcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
  localparam int STALL_LIMIT = 5000;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           raw_levels;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           pressed_now;
  logic [15:0]           press_events;
  logic [15:0]           release_events;
  logic [3:0]            combo_fired;

  int fail_count;
  int pending_results;
  int src_idle_pct;
  int sink_stall_pct;
  int quiet_cycles;

  button_debounce_chord_detect uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_levels    (raw_levels),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pressed_now   (pressed_now),
    .press_events  (press_events),
    .release_events(release_events),
    .combo_fired   (combo_fired)
  );

  bdcd_scan_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .raw_levels     (raw_levels),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pressed_now    (pressed_now),
    .press_events   (press_events),
    .release_events (release_events),
    .combo_fired    (combo_fired),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: give up when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_FULL:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      PACE_SRC_IDLE:   begin src_idle_pct = 67; sink_stall_pct = 0;  end
      PACE_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 67; end
      default:         begin src_idle_pct = 17; sink_stall_pct = 17; end
    endcase
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_scan(btn_vec_t levels);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    raw_levels <= levels;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic btn_vec_t pick_combo();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return btn_vec_t'($urandom);
      default: return (btn_vec_t'(1) << $urandom_range(15)) |
                      (btn_vec_t'(1) << $urandom_range(15)) |
                      (btn_vec_t'($urandom_range(1)) << $urandom_range(15));
    endcase
  endfunction

  task automatic randomize_setup(int phase);
    cnt_t     limit;
    btn_vec_t enable;
    case ($urandom_range(5))
      0:       limit = '0;
      1:       limit = 8'd1;
      2, 3:    limit = cnt_t'($urandom_range(2, 4));
      4:       limit = cnt_t'($urandom_range(5, 12));
      default: limit = cnt_t'($urandom_range(255));
    endcase
    if (phase == 2) enable = '0;
    else if ($urandom_range(3) == 0) enable = '1;
    else enable = btn_vec_t'($urandom | $urandom);
    write_reg(CFG_DEBOUNCE_LIMIT, CFG_DATA_W'(limit));
    write_reg(CFG_ACTIVE_LOW, ($urandom_range(3) == 0) ? '0 : btn_vec_t'($urandom));
    write_reg(CFG_BUTTON_ENABLE, enable);
    for (int k = 0; k < NUM_COMBOS; k++)
      write_reg(CFG_COMBO_A + CFG_IDX_W'(k), pick_combo());
  endtask

  // Held button levels that move now and then, with bounce and noise scans
  task automatic run_phase(int count);
    btn_vec_t held;
    btn_vec_t levels;
    held = btn_vec_t'($urandom);
    repeat (count) begin
      if ($urandom_range(99) < 12) held = held ^ btn_vec_t'($urandom & $urandom);
      case ($urandom_range(9))
        0:       levels = btn_vec_t'($urandom);
        1, 2:    levels = held ^ btn_vec_t'($urandom & $urandom & $urandom);
        default: levels = held;
      endcase
      send_scan(levels);
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    raw_levels = '0;
    set_pace(PACE_FULL);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Everything disabled straight out of reset
    send_scan(16'hFFFF);
    wait_drained();
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd0);
    write_reg(CFG_ACTIVE_LOW, 16'h0000);
    write_reg(CFG_BUTTON_ENABLE, 16'h7FFF);
    write_reg(CFG_COMBO_A, 16'h0003);
    write_reg(CFG_COMBO_A + 3'd1, 16'h0000);
    write_reg(CFG_COMBO_A + 3'd2, 16'h8001);
    write_reg(CFG_COMBO_A + 3'd3, 16'h00F0);
    write_reg(CFG_NO_REG, 16'hFFFF);
    send_scan(16'h0001);
    send_scan(16'h0003);
    send_scan(16'h0003);
    send_scan(16'hFFFF);
    send_scan(16'h0000);
    send_scan(16'h00F3);
    send_scan(16'h0000);

    // Active-low pins with a short debounce window
    wait_drained();
    write_reg(CFG_ACTIVE_LOW, 16'hFFFF);
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd2);
    repeat (3) send_scan(16'hFFFF);
    repeat (3) send_scan(16'h0000);

    // Disable buttons while held: no release reported
    wait_drained();
    write_reg(CFG_BUTTON_ENABLE, 16'h00FF);
    send_scan(16'h0000);

    // Lower the limit under a running counter
    wait_drained();
    write_reg(CFG_ACTIVE_LOW, 16'h0000);
    write_reg(CFG_BUTTON_ENABLE, 16'hFFFF);
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd20);
    repeat (5) send_scan(16'hFF00);
    wait_drained();
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd1);
    send_scan(16'hFF00);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      randomize_setup(p);
      set_pace(pace_e'(p % 4));
      run_phase(80);
    end

    // Hold one level long enough for a counter to reach its top value
    wait_drained();
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd0);
    write_reg(CFG_ACTIVE_LOW, 16'h0000);
    write_reg(CFG_BUTTON_ENABLE, 16'hFFFF);
    send_scan(16'h0000);
    wait_drained();
    write_reg(CFG_DEBOUNCE_LIMIT, 16'd255);
    set_pace(PACE_BOTH);
    repeat (300) send_scan(16'hFFFF);

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/bdcd_pkg.sv
src/bdcd_lane.sv
src/bdcd_combo.sv
src/button_debounce_chord_detect.sv
src/bdcd_checker.sv
tb/sv/bdcd_scan_checker.sv
tb/sv/tb_button_debounce_chord_detect.sv
